// File: rtl/csvp_pkg.sv
// Package for the CSV record parser: item types, phase encoding, status codes
// and the ASCII constants that the parser compares against. No dependencies.
`default_nettype none

package csvp_pkg;

   localparam int TEXT_LEN_W = 11;

   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_ONE     = 8'h31;
   localparam logic [7:0] CH_NINE    = 8'h39;
   localparam logic [7:0] CH_COMMA   = 8'h2C;
   localparam logic [7:0] CH_NEWLINE = 8'h0A;
   localparam logic [7:0] CH_QUOTE   = 8'h22;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_EOI       = 3'd1,
      ST_BAD_ID    = 3'd2,
      ST_OVERFLOW  = 3'd3,
      ST_COMMA     = 3'd4,
      ST_FLAG      = 3'd5,
      ST_NEWLINE   = 3'd6,
      ST_END_QUOTE = 3'd7
   } status_type;

   typedef enum logic {
      KIND_TEXT   = 1'b0,
      KIND_RECORD = 1'b1
   } kind_type;

   typedef enum logic [9:0] {
      PH_START      = 10'b00_0000_0001,
      PH_ID         = 10'b00_0000_0010,
      PH_FLAG1      = 10'b00_0000_0100,
      PH_COMMA1     = 10'b00_0000_1000,
      PH_FLAG2      = 10'b00_0001_0000,
      PH_COMMA2     = 10'b00_0010_0000,
      PH_TEXT_START = 10'b00_0100_0000,
      PH_PLAIN      = 10'b00_1000_0000,
      PH_QUOTED     = 10'b01_0000_0000,
      PH_QUOTE_SEEN = 10'b10_0000_0000
   } phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_input;
   } req_type;

   typedef struct packed {
      logic                  kind;
      logic [7:0]            text_byte;
      logic [63:0]           record_id;
      logic                  first_flag;
      logic                  second_flag;
      logic [TEXT_LEN_W-1:0] text_length;
      logic [2:0]            status;
   } rsp_type;

endpackage

`default_nettype wire

// File: rtl/csvp_in_stage.sv
// Input register of the CSV record parser: holds one accepted item until the
// parse step takes it. Depends on csvp_pkg for the item type.
`default_nettype none

module csvp_in_stage (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire csvp_pkg::req_type req_data,
   input  wire logic             advance,
   output logic                  item_valid,
   output csvp_pkg::req_type     item
);
   import csvp_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   req_type item_ff;

   assign req_stall  = valid_ff && !advance;
   assign item_valid = valid_ff;
   assign item       = item_ff;

   always_comb begin
      valid_in = valid_ff;
      if (!req_stall) begin
         valid_in = req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         item_ff <= req_data;
      end
   end

endmodule

`default_nettype wire

// File: rtl/csvp_parser.sv
// Parse step of the CSV record parser: record state registers and the logic
// that turns one item into at most one result. Depends on csvp_pkg.
`default_nettype none

module csvp_parser #(
   parameter int MAX_TEXT_BYTES = 1024
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              step,
   input  wire csvp_pkg::req_type item,
   output logic                   res_valid,
   output csvp_pkg::rsp_type      res
);
   import csvp_pkg::*;

   localparam int CNT_W = $clog2(MAX_TEXT_BYTES + 1);

   phase_type         phase_ff, phase_in;
   logic [63:0]       id_ff, id_in;
   logic              flag1_ff, flag1_in;
   logic              flag2_ff, flag2_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              halted_ff, halted_in;

   logic [7:0]        b;
   logic              eoi;
   logic              room;
   logic [3:0]        digit_full;
   logic [67:0]       id_times_ten;
   logic [67:0]       id_next_wide;
   logic [CNT_W+10:0] count_ext;

   logic              do_text;
   logic              do_record;
   logic              do_error;
   status_type        err_code;

   assign b            = item.data_byte;
   assign eoi          = item.end_of_input;
   assign room         = count_ff < CNT_W'(MAX_TEXT_BYTES);
   assign digit_full   = 4'(b - CH_ZERO);
   assign id_times_ten = {1'b0, id_ff, 3'b000} + {3'b000, id_ff, 1'b0};
   assign id_next_wide = id_times_ten + {64'd0, digit_full};
   assign count_ext    = (CNT_W + TEXT_LEN_W)'(count_ff);

   always_comb begin
      do_text   = 1'b0;
      do_record = 1'b0;
      do_error  = 1'b0;
      err_code  = ST_OK;
      phase_in  = phase_ff;
      id_in     = id_ff;
      flag1_in  = flag1_ff;
      flag2_in  = flag2_ff;
      count_in  = count_ff;
      halted_in = halted_ff;
      if (step && !halted_ff) begin
         case (phase_ff)
            PH_START: begin
               if (eoi) begin
                  do_error = 1'b1;
                  err_code = ST_EOI;
               end else if (!(b inside {[CH_ONE:CH_NINE]})) begin
                  do_error = 1'b1;
                  err_code = ST_BAD_ID;
               end else begin
                  id_in    = {60'd0, digit_full};
                  phase_in = PH_ID;
               end
            end
            PH_ID: begin
               if (eoi) begin
                  do_error = 1'b1;
                  err_code = ST_COMMA;
               end else if (b == CH_COMMA) begin
                  phase_in = PH_FLAG1;
               end else if (!(b inside {[CH_ZERO:CH_NINE]})) begin
                  do_error = 1'b1;
                  err_code = ST_COMMA;
               end else if (id_next_wide[67:64] != 4'd0) begin
                  do_error = 1'b1;
                  err_code = ST_OVERFLOW;
               end else begin
                  id_in = id_next_wide[63:0];
               end
            end
            PH_FLAG1, PH_FLAG2: begin
               if (eoi || !(b inside {CH_ZERO, CH_ONE})) begin
                  do_error = 1'b1;
                  err_code = ST_FLAG;
               end else if (phase_ff == PH_FLAG1) begin
                  flag1_in = b[0];
                  phase_in = PH_COMMA1;
               end else begin
                  flag2_in = b[0];
                  phase_in = PH_COMMA2;
               end
            end
            PH_COMMA1, PH_COMMA2: begin
               if (eoi || b != CH_COMMA) begin
                  do_error = 1'b1;
                  err_code = ST_COMMA;
               end else if (phase_ff == PH_COMMA1) begin
                  phase_in = PH_FLAG2;
               end else begin
                  phase_in = PH_TEXT_START;
               end
            end
            PH_TEXT_START: begin
               if (eoi) begin
                  do_error = 1'b1;
                  err_code = ST_NEWLINE;
               end else if (b == CH_NEWLINE) begin
                  do_record = 1'b1;
               end else if (b == CH_QUOTE) begin
                  phase_in = PH_QUOTED;
               end else begin
                  phase_in = PH_PLAIN;
                  if (!room) begin
                     do_error = 1'b1;
                     err_code = ST_NEWLINE;
                  end else begin
                     do_text = 1'b1;
                  end
               end
            end
            PH_PLAIN: begin
               if (eoi) begin
                  do_error = 1'b1;
                  err_code = ST_NEWLINE;
               end else if (b == CH_NEWLINE) begin
                  do_record = 1'b1;
               end else if (!room) begin
                  do_error = 1'b1;
                  err_code = ST_NEWLINE;
               end else begin
                  do_text = 1'b1;
               end
            end
            PH_QUOTED: begin
               if (eoi) begin
                  do_error = 1'b1;
                  err_code = ST_END_QUOTE;
               end else if (b == CH_QUOTE) begin
                  phase_in = PH_QUOTE_SEEN;
               end else if (!room) begin
                  do_error = 1'b1;
                  err_code = ST_END_QUOTE;
               end else begin
                  do_text = 1'b1;
               end
            end
            PH_QUOTE_SEEN: begin
               if (eoi) begin
                  do_error = 1'b1;
                  err_code = ST_NEWLINE;
               end else if (b == CH_QUOTE) begin
                  if (!room) begin
                     do_error = 1'b1;
                     err_code = ST_END_QUOTE;
                  end else begin
                     phase_in = PH_QUOTED;
                     do_text  = 1'b1;
                  end
               end else if (b == CH_NEWLINE) begin
                  do_record = 1'b1;
               end else begin
                  do_error = 1'b1;
                  err_code = ST_NEWLINE;
               end
            end
            default: begin
               phase_in = PH_START;
               id_in    = 64'd0;
               flag1_in = 1'b0;
               flag2_in = 1'b0;
               count_in = '0;
            end
         endcase
         if (do_text) begin
            count_in = count_ff + CNT_W'(1);
         end
         if (do_record) begin
            phase_in = PH_START;
            id_in    = 64'd0;
            flag1_in = 1'b0;
            flag2_in = 1'b0;
            count_in = '0;
         end
         if (do_error) begin
            halted_in = 1'b1;
         end
      end
   end

   always_comb begin
      res       = '0;
      res_valid = do_text || do_record || do_error;
      if (do_text) begin
         res.kind      = KIND_TEXT;
         res.text_byte = b;
      end else if (do_record) begin
         res.kind        = KIND_RECORD;
         res.record_id   = id_ff;
         res.first_flag  = flag1_ff;
         res.second_flag = flag2_ff;
         res.text_length = count_ext[TEXT_LEN_W-1:0];
         res.status      = ST_OK;
      end else if (do_error) begin
         res.kind   = KIND_RECORD;
         res.status = err_code;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_START;
         id_ff     <= 64'd0;
         flag1_ff  <= 1'b0;
         flag2_ff  <= 1'b0;
         count_ff  <= '0;
         halted_ff <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         id_ff     <= id_in;
         flag1_ff  <= flag1_in;
         flag2_ff  <= flag2_in;
         count_ff  <= count_in;
         halted_ff <= halted_in;
      end
   end

`ifndef SYNTH
   a_no_result_when_halted: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> !halted_ff)
      else $error("result produced while halted");

   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_TEXT_BYTES))
      else $error("text count beyond limit");

   a_error_halts: assert property (@(posedge clock) disable iff (reset)
      (res_valid && res.kind == KIND_RECORD && res.status != ST_OK) |=> halted_ff)
      else $error("error result did not halt the parser");

   a_halt_sticks: assert property (@(posedge clock) disable iff (reset)
      halted_ff |=> halted_ff)
      else $error("halt released without reset");

   a_record_clears: assert property (@(posedge clock) disable iff (reset)
      (res_valid && res.kind == KIND_RECORD && res.status == ST_OK)
      |=> (phase_ff == PH_START && count_ff == '0 && id_ff == 64'd0))
      else $error("record end did not clear the record state");
`endif

endmodule

`default_nettype wire

// File: rtl/csvp_out_stage.sv
// Result register of the CSV record parser: holds one result until the
// receiving side takes it. Depends on csvp_pkg for the result type.
`default_nettype none

module csvp_out_stage (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              load,
   input  wire csvp_pkg::rsp_type load_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output csvp_pkg::rsp_type      rsp_data
);
   import csvp_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   rsp_type data_ff;

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

endmodule

`default_nettype wire

// File: rtl/csv_record_parser.sv
// Top level of the CSV record parser: input register, parse step and result
// register. Depends on csvp_pkg, csvp_in_stage, csvp_parser, csvp_out_stage.
//
//   channel   direction  handshake              payload
//   req       in         req_valid / req_stall  req_data (one byte or end mark)
//   rsp       out        rsp_valid / rsp_stall  rsp_data (text byte or record end)
//
// An item is held in the input register until the parse step takes it; its
// result, if any, is then loaded into the result register, which drives
// rsp_valid. One item is taken every cycle while rsp is not stalled; the record
// state update is the single step that sets this rate. Synchronous reset clears
// the parser to the start of a record. A stall on rsp while rsp_valid is high
// holds the input register and so stalls req.
`default_nettype none

module csv_record_parser #(
   parameter int MAX_TEXT_BYTES = 1024
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire csvp_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output csvp_pkg::rsp_type      rsp_data
);
   import csvp_pkg::*;

   logic    item_valid;
   req_type item;
   logic    advance;
   logic    res_valid;
   rsp_type res;

   assign advance = item_valid && (!rsp_valid || !rsp_stall);

   csvp_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   csvp_parser #(
      .MAX_TEXT_BYTES (MAX_TEXT_BYTES)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .item      (item),
      .res_valid (res_valid),
      .res       (res)
   );

   csvp_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .load      (res_valid),
      .load_data (res),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire
